### design/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

   localparam int TIMEOUT_BITS = 16;
   localparam int TIMEOUT_REG_BITS = 16;
   localparam int CMP_BITS = (TIMEOUT_BITS > TIMEOUT_REG_BITS) ? TIMEOUT_BITS : TIMEOUT_REG_BITS;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [7:0] MSB_MASK = 8'h80;

   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_RELEASE  = 3'd1;
   localparam logic [2:0] CMD_START    = 3'd2;
   localparam logic [2:0] CMD_REPSTART = 3'd3;
   localparam logic [2:0] CMD_STOP     = 3'd4;
   localparam logic [2:0] CMD_WRITE    = 3'd5;
   localparam logic [2:0] CMD_READ     = 3'd6;

   localparam logic [CSR_INDEX_BITS-1:0] REG_HALF_PERIOD    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STRETCH_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STRETCH_TIMEOUT = 2'd2;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       ack_after_read;
      logic       sda_in;
      logic       scl_in;
   } i2cm_item_type;

   typedef struct packed {
      logic          valid;
      i2cm_item_type item;
   } i2cm_queue_type;

endpackage

### design/i2cm_front.sv
// Front end: accepts tick transactions, decodes the command and queues them.
module i2cm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2:0]              req_tuser,  // op
   input  logic [15:0]             req_tdata,  // tx_byte, ack_after_read, sda_in, scl_in
   output i2cm_pkg::i2cm_queue_type queue_head,
   input  logic                    queue_pop
);
   import i2cm_pkg::*;

   i2cm_item_type entry_ff [2];
   logic          wr_ptr_ff;
   logic          wr_ptr_in;
   logic          rd_ptr_ff;
   logic          rd_ptr_in;
   logic [1:0]    count_ff;
   logic [1:0]    count_in;
   logic          push;
   i2cm_item_type decoded;

   always_comb begin
      decoded.tx_byte        = req_tdata[7:0];
      decoded.ack_after_read = req_tdata[8];
      decoded.sda_in         = req_tdata[9];
      decoded.scl_in         = req_tdata[10];
      unique case (req_tuser) inside
         CMD_RELEASE, CMD_START, CMD_REPSTART, CMD_STOP, CMD_WRITE, CMD_READ: begin
            decoded.cmd = req_tuser;
         end
         default: begin
            decoded.cmd = CMD_TICK;
         end
      endcase
   end

   assign req_tready       = (count_ff != 2'd2);
   assign push             = req_tvalid && req_tready;
   assign queue_head.valid = (count_ff != 2'd0);
   assign queue_head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = queue_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(queue_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

### design/i2cm_engine.sv
// Back end: steps the bus phase sequencer once per queued tick and registers the response.
module i2cm_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  i2cm_pkg::i2cm_queue_type            queue_head,
   output logic                                queue_pop,
   input  logic                                csr_we,
   input  logic [i2cm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [i2cm_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata
);
   import i2cm_pkg::*;

   localparam logic [4:0] PH_IDLE      = 5'd0;
   localparam logic [4:0] PH_REL_SCL   = 5'd1;
   localparam logic [4:0] PH_REL_SDA   = 5'd2;
   localparam logic [4:0] PH_REL_HOLD  = 5'd3;
   localparam logic [4:0] PH_ST_REL    = 5'd4;
   localparam logic [4:0] PH_ST_CHECK  = 5'd5;
   localparam logic [4:0] PH_ST_SCL    = 5'd6;
   localparam logic [4:0] PH_RS_A      = 5'd7;
   localparam logic [4:0] PH_RS_B      = 5'd8;
   localparam logic [4:0] PH_RS_C      = 5'd9;
   localparam logic [4:0] PH_SP_A      = 5'd10;
   localparam logic [4:0] PH_SP_B      = 5'd11;
   localparam logic [4:0] PH_SP_C      = 5'd12;
   localparam logic [4:0] PH_WB_DATA   = 5'd13;
   localparam logic [4:0] PH_WB_HIGH   = 5'd14;
   localparam logic [4:0] PH_WB_LOW    = 5'd15;
   localparam logic [4:0] PH_RB_HIGH   = 5'd16;
   localparam logic [4:0] PH_RB_SAMPLE = 5'd17;
   localparam logic [4:0] PH_RD_TAIL   = 5'd18;
   localparam logic [4:0] PH_FINISH    = 5'd19;

   logic [7:0]                  half_period_ff;
   logic                        stretch_enable_ff;
   logic [TIMEOUT_REG_BITS-1:0] stretch_timeout_ff;

   logic [4:0]              phase_ff, phase_in;
   logic [2:0]              active_cmd_ff, active_cmd_in;
   logic [3:0]              bit_index_ff, bit_index_in;
   logic [7:0]              shift_ff, shift_in;
   logic [7:0]              delay_ff, delay_in;
   logic [TIMEOUT_BITS-1:0] stretch_count_ff, stretch_count_in;
   logic                    sda_level_ff, sda_level_in;
   logic                    scl_level_ff, scl_level_in;
   logic                    ack_choice_ff, ack_choice_in;
   logic                    stretch_wait_ff, stretch_wait_in;
   logic [7:0]              rx_byte_ff, rx_byte_in;
   logic                    ack_bit_ff, ack_bit_in;
   logic                    bus_error_ff, bus_error_in;
   logic                    timed_out_ff, timed_out_in;
   logic                    done;
   logic                    run;
   logic                    rsp_valid_ff;
   logic [15:0]             rsp_data_ff;
   i2cm_item_type           item;

   assign item      = queue_head.item;
   assign queue_pop = queue_head.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      phase_in         = phase_ff;
      active_cmd_in    = active_cmd_ff;
      bit_index_in     = bit_index_ff;
      shift_in         = shift_ff;
      delay_in         = delay_ff;
      stretch_count_in = stretch_count_ff;
      sda_level_in     = sda_level_ff;
      scl_level_in     = scl_level_ff;
      ack_choice_in    = ack_choice_ff;
      stretch_wait_in  = stretch_wait_ff;
      rx_byte_in       = rx_byte_ff;
      ack_bit_in       = ack_bit_ff;
      bus_error_in     = bus_error_ff;
      timed_out_in     = timed_out_ff;
      done             = 1'b0;
      run              = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (item.cmd != CMD_TICK) begin
            active_cmd_in   = item.cmd;
            bus_error_in    = 1'b0;
            timed_out_in    = 1'b0;
            delay_in        = 8'd0;
            stretch_wait_in = 1'b0;
            bit_index_in    = 4'd0;
            run             = 1'b1;
            unique case (item.cmd)
               CMD_RELEASE:  phase_in = PH_REL_SCL;
               CMD_START:    phase_in = PH_ST_REL;
               CMD_REPSTART: phase_in = PH_RS_A;
               CMD_STOP:     phase_in = PH_SP_A;
               CMD_WRITE: begin
                  shift_in = item.tx_byte;
                  phase_in = PH_WB_DATA;
               end
               default: begin
                  ack_choice_in = item.ack_after_read;
                  shift_in      = 8'd0;
                  phase_in      = PH_RB_HIGH;
               end
            endcase
         end
      end else if (stretch_wait_ff) begin
         if (item.scl_in) begin
            stretch_wait_in  = 1'b0;
            stretch_count_in = '0;
            delay_in         = half_period_ff;
         end else if (CMP_BITS'(stretch_count_ff) >= CMP_BITS'(stretch_timeout_ff) ||
                      stretch_count_ff == '1) begin
            timed_out_in     = 1'b1;
            stretch_wait_in  = 1'b0;
            stretch_count_in = '0;
            delay_in         = half_period_ff;
         end else begin
            stretch_count_in = stretch_count_ff + TIMEOUT_BITS'(1);
         end
      end else if (delay_ff != 8'd0) begin
         delay_in = delay_ff - 8'd1;
      end else begin
         run = 1'b1;
      end

      if (run) begin
         unique case (phase_in)
            PH_REL_SCL: begin
               scl_level_in = 1'b1;
               delay_in     = half_period_ff;
               phase_in     = PH_REL_SDA;
            end
            PH_REL_SDA: begin
               sda_level_in = 1'b1;
               delay_in     = half_period_ff;
               bit_index_in = 4'd3;
               phase_in     = PH_REL_HOLD;
            end
            PH_REL_HOLD: begin
               if (bit_index_in != 4'd0) begin
                  bit_index_in = bit_index_in - 4'd1;
                  delay_in     = half_period_ff;
               end else begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
            end
            PH_ST_REL: begin
               sda_level_in = 1'b1;
               scl_level_in = 1'b1;
               delay_in     = half_period_ff;
               phase_in     = PH_ST_CHECK;
            end
            PH_ST_CHECK: begin
               if (!item.sda_in || !item.scl_in) begin
                  bus_error_in = 1'b1;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
               end else begin
                  sda_level_in = 1'b0;
                  delay_in     = half_period_ff;
                  phase_in     = PH_ST_SCL;
               end
            end
            PH_ST_SCL: begin
               scl_level_in = 1'b0;
               delay_in     = half_period_ff;
               phase_in     = PH_FINISH;
            end
            PH_RS_A: begin
               sda_level_in = 1'b1;
               scl_level_in = 1'b0;
               delay_in     = half_period_ff;
               phase_in     = PH_RS_B;
            end
            PH_RS_B: begin
               sda_level_in = 1'b1;
               delay_in     = half_period_ff;
               phase_in     = PH_RS_C;
            end
            PH_RS_C, PH_SP_B, PH_WB_HIGH, PH_RB_HIGH: begin
               scl_level_in = 1'b1;
               if (stretch_enable_ff) begin
                  stretch_wait_in  = 1'b1;
                  stretch_count_in = '0;
               end else begin
                  delay_in = half_period_ff;
               end
               if (phase_in == PH_RB_HIGH) begin
                  sda_level_in = 1'b1;
               end
               unique case (phase_in)
                  PH_RS_C:    phase_in = PH_FINISH;
                  PH_SP_B:    phase_in = PH_SP_C;
                  PH_WB_HIGH: phase_in = PH_WB_LOW;
                  default:    phase_in = PH_RB_SAMPLE;
               endcase
            end
            PH_SP_A: begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b0;
               delay_in     = half_period_ff;
               phase_in     = PH_SP_B;
            end
            PH_SP_C: begin
               sda_level_in = 1'b1;
               delay_in     = half_period_ff;
               phase_in     = PH_FINISH;
            end
            PH_WB_DATA: begin
               sda_level_in = (shift_in & MSB_MASK) != 8'd0;
               phase_in     = PH_WB_HIGH;
            end
            PH_WB_LOW: begin
               scl_level_in = 1'b0;
               delay_in     = half_period_ff;
               if (active_cmd_in == CMD_WRITE) begin
                  shift_in     = {shift_in[6:0], 1'b0};
                  bit_index_in = bit_index_in + 4'd1;
                  phase_in     = (bit_index_in >= 4'd8) ? PH_RB_HIGH : PH_WB_DATA;
               end else begin
                  phase_in = PH_RD_TAIL;
               end
            end
            PH_RB_SAMPLE: begin
               scl_level_in = 1'b0;
               delay_in     = half_period_ff;
               if (active_cmd_in == CMD_WRITE) begin
                  ack_bit_in = item.sda_in;
                  phase_in   = PH_FINISH;
               end else begin
                  shift_in     = {shift_in[6:0], item.sda_in};
                  bit_index_in = bit_index_in + 4'd1;
                  if (bit_index_in >= 4'd8) begin
                     rx_byte_in = shift_in;
                     shift_in   = ack_choice_in ? 8'd0 : MSB_MASK;
                     phase_in   = PH_WB_DATA;
                  end else begin
                     phase_in = PH_RB_HIGH;
                  end
               end
            end
            PH_RD_TAIL: begin
               delay_in = half_period_ff;
               phase_in = PH_FINISH;
            end
            PH_FINISH: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff     <= 8'd2;
         stretch_enable_ff  <= 1'b0;
         stretch_timeout_ff <= TIMEOUT_REG_BITS'(20);
      end else if (csr_we) begin
         case (csr_index)
            REG_HALF_PERIOD:     half_period_ff     <= csr_wdata[7:0];
            REG_STRETCH_ENABLE:  stretch_enable_ff  <= csr_wdata[0];
            REG_STRETCH_TIMEOUT: stretch_timeout_ff <= csr_wdata[TIMEOUT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         active_cmd_ff    <= CMD_TICK;
         bit_index_ff     <= 4'd0;
         shift_ff         <= 8'd0;
         delay_ff         <= 8'd0;
         stretch_count_ff <= '0;
         sda_level_ff     <= 1'b1;
         scl_level_ff     <= 1'b1;
         ack_choice_ff    <= 1'b0;
         stretch_wait_ff  <= 1'b0;
         rx_byte_ff       <= 8'd0;
         ack_bit_ff       <= 1'b0;
         bus_error_ff     <= 1'b0;
         timed_out_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (queue_pop) begin
            phase_ff         <= phase_in;
            active_cmd_ff    <= active_cmd_in;
            bit_index_ff     <= bit_index_in;
            shift_ff         <= shift_in;
            delay_ff         <= delay_in;
            stretch_count_ff <= stretch_count_in;
            sda_level_ff     <= sda_level_in;
            scl_level_ff     <= scl_level_in;
            ack_choice_ff    <= ack_choice_in;
            stretch_wait_ff  <= stretch_wait_in;
            rx_byte_ff       <= rx_byte_in;
            ack_bit_ff       <= ack_bit_in;
            bus_error_ff     <= bus_error_in;
            timed_out_ff     <= timed_out_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         rsp_data_ff <= {1'b0, timed_out_in, bus_error_in, ack_bit_in, rx_byte_in, done,
                         phase_in != PH_IDLE, scl_level_in, sda_level_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (!stretch_wait_ff && delay_ff == 8'd0))
      else $error("Engine idle with a wait still pending.");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd8)
      else $error("Bit index beyond one byte.");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[3]) |-> !rsp_data_ff[2])
      else $error("Response reports done while still busy.");

   a_wait_only_stretch: assert property (@(posedge clock) disable iff (reset)
      stretch_wait_ff |-> (stretch_enable_ff || $past(stretch_enable_ff) || scl_level_ff))
      else $error("Clock stretch wait without SCL released.");

endmodule

### design/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: command queue front end and phase sequencer.
// Each request transaction is one timing tick carrying the sampled SDA and SCL levels and an
// optional command, and yields exactly one response transaction with the line drive levels,
// busy and done flags and the held receive byte, ACK bit and error flags. The block sustains
// one transaction per clock unless the response output is stalled, one sequencer step per tick.
// A tick passes through a two-entry queue and then the sequencer's response register, which
// is written when the tick is popped from the queue. Configuration registers are written
// through the csr port; the user must do so only while no command is in progress, as the
// block itself does not enforce it.
module i2c_master_bit_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2:0]                          req_tuser,  // op
   input  logic [15:0]                         req_tdata,  // tx_byte, ack_after_read, sda_in, scl_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sda_release, scl_release, busy_res, done_res, rx_byte, ack_bit, bus_error,
   // stretch_timed_out
   output logic [15:0]                         rsp_tdata,
   input  logic                                csr_we,
   input  logic [i2cm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [i2cm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import i2cm_pkg::*;

   i2cm_queue_type queue_head;
   logic           queue_pop;

   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_head (queue_head),
      .queue_pop  (queue_pop)
   );

   i2cm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .queue_head (queue_head),
      .queue_pop  (queue_pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
